@@ rtl/core/stl_pkg.sv @@
// Shared types, constants and helper functions for the script token lexer.
// No dependencies; imported by every module of the block.
package stl_pkg;

  localparam int LINE_W = 20;
  localparam int OFF_W  = 32;
  localparam int LEN_W  = 16;
  localparam int KIND_W = 5;

  // Longest keyword in the table and number of keywords
  localparam int KW_BYTES = 11;
  localparam int KW_COUNT = 25;

  localparam logic [LINE_W-1:0] MAX20 = '1;
  localparam logic [LEN_W-1:0]  MAX16 = '1;
  localparam logic [OFF_W-1:0]  MAX32 = '1;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Token kinds
  localparam logic [KIND_W-1:0] K_PUNCT    = 5'd0;
  localparam logic [KIND_W-1:0] K_IDENT    = 5'd1;
  localparam logic [KIND_W-1:0] K_NUMBER   = 5'd2;
  localparam logic [KIND_W-1:0] K_STRING   = 5'd3;
  localparam logic [KIND_W-1:0] K_COMMENT  = 5'd4;
  localparam logic [KIND_W-1:0] K_END      = 5'd5;
  localparam logic [KIND_W-1:0] K_FIRST_KW = 5'd6;

  // Byte codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [2:0] {
    M_IDLE   = 3'd0,
    M_IDENT  = 3'd1,
    M_NUMBER = 3'd2,
    M_STRING = 3'd3,
    M_SLASH  = 3'd4,
    M_BSKIP  = 3'd5,
    M_BBODY  = 3'd6,
    M_LINE   = 3'd7
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0]        punct_char;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] column;
    logic [OFF_W-1:0]  start_offset;
    logic [LEN_W-1:0]  length;
    logic              last;
  } tok_t;

  // Keyword text, right-justified; first character in the highest used byte
  localparam logic [KW_BYTES*8-1:0] KW_TXT [KW_COUNT] = '{
    "do", "if", "or", "for", "var", "end", "and", "xor", "pow",
    "true", "else", "null", "false", "while", "break", "bitor", "super",
    "class", "return", "bitand", "require", "extends", "function",
    "continue", "constructor"
  };
  localparam logic [3:0] KW_SIZE [KW_COUNT] = '{
    4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd11
  };

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           b == CH_UNDER || b == CH_DOLLAR;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_quote(input logic [7:0] b);
    return b == CH_DQUOTE || b == CH_SQUOTE;
  endfunction

  function automatic logic [LINE_W-1:0] inc20(input logic [LINE_W-1:0] x);
    return (x == MAX20) ? x : x + 1'b1;
  endfunction

  function automatic logic [LINE_W-1:0] add20(input logic [LINE_W-1:0] x,
                                              input logic [LEN_W-1:0] y);
    logic [LINE_W:0] s;
    s = {1'b0, x} + {5'd0, y};
    return s[LINE_W] ? MAX20 : s[LINE_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] inc16(input logic [LEN_W-1:0] x);
    return (x == MAX16) ? x : x + 1'b1;
  endfunction

  function automatic logic [OFF_W-1:0] inc32(input logic [OFF_W-1:0] x);
    return (x == MAX32) ? x : x + 1'b1;
  endfunction

  // Scanner mode entered when a byte is seen from idle
  function automatic mode_t idle_mode(input logic [7:0] b);
    if (is_alpha(b)) return M_IDENT;
    else if (is_digit(b)) return M_NUMBER;
    else if (is_quote(b)) return M_STRING;
    else if (b == CH_SLASH) return M_SLASH;
    else return M_IDLE;
  endfunction

  // Parallel keyword compare; word byte i sits at w[8*i +: 8]
  function automatic logic [KIND_W-1:0] kw_kind(input logic [KW_BYTES*8-1:0] w,
                                                input logic [LEN_W-1:0] len);
    logic [KIND_W-1:0] k;
    logic hit;
    int idx;
    k = K_IDENT;
    for (int j = KW_COUNT - 1; j >= 0; j--) begin
      hit = (len == LEN_W'(KW_SIZE[j]));
      for (int i = 0; i < KW_BYTES; i++) begin
        if (i < int'(KW_SIZE[j])) begin
          idx = int'(KW_SIZE[j]) - 1 - i;
          if (w[8*i +: 8] != KW_TXT[j][8*idx +: 8]) hit = 1'b0;
        end
      end
      if (hit) k = K_FIRST_KW + KIND_W'(j);
    end
    return k;
  endfunction

  function automatic tok_t mk_tok(input logic [KIND_W-1:0] kind,
                                  input logic [7:0] pch,
                                  input logic [LINE_W-1:0] ln,
                                  input logic [LINE_W-1:0] cl,
                                  input logic [OFF_W-1:0] so,
                                  input logic [LEN_W-1:0] len);
    tok_t t;
    t.kind         = kind;
    t.punct_char   = pch;
    t.line         = ln;
    t.column       = cl;
    t.start_offset = so;
    t.length       = len;
    t.last         = 1'b0;
    return t;
  endfunction

endpackage

@@ rtl/core/script_token_lexer_top.sv @@
// Top level of the script token lexer: front scanner, token queue, output stage.
// Depends on stl_pkg, stl_front, stl_queue and stl_back.
//
//  channel | signals                                      | direction
//  in      | in_valid, in_stall, opcode, text_byte        | byte or end of text in
//  out     | out_valid, out_stall, kind .. length, last   | one token per transfer
//
// One byte is taken per cycle while in_stall is low; the scanner state is registered.
// A byte yields zero to two tokens; tokens leave one per cycle while out_stall is low,
// registered first by the queue write and then by the output register.
// in_stall rises while the four-entry token queue holds more than two tokens.
// Synchronous reset returns the scanner to idle and empties the queue.
module script_token_lexer_top import stl_pkg::*; #(
  parameter int MAX_KEYWORD_LEN = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  kind,
  output logic [7:0]  punct_char,
  output logic [19:0] line,
  output logic [19:0] column,
  output logic [31:0] start_offset,
  output logic [15:0] length,
  output logic        last
);

  logic       accept;
  logic [1:0] push_n;
  tok_t       tok0, tok1, head, tok;
  logic       not_empty, full, pop;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  stl_front #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .opcode    (opcode),
    .text_byte (text_byte),
    .push_n    (push_n),
    .tok0      (tok0),
    .tok1      (tok1)
  );

  stl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .tok0      (tok0),
    .tok1      (tok1),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  stl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tok       (tok)
  );

  assign kind         = tok.kind;
  assign punct_char   = tok.punct_char;
  assign line         = tok.line;
  assign column       = tok.column;
  assign start_offset = tok.start_offset;
  assign length       = tok.length;
  assign last         = tok.last;

endmodule

@@ rtl/core/stl_front.sv @@
// Front end: accepts bytes, runs the scanner state and builds up to two tokens.
// Depends on stl_pkg; feeds stl_queue.
module stl_front import stl_pkg::*; #(
  parameter int MAX_KEYWORD_LEN = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        opcode,
  input  logic [7:0]  text_byte,
  output logic [1:0]  push_n,
  output tok_t        tok0,
  output tok_t        tok1
);

  localparam int IDX_W = $clog2(MAX_KEYWORD_LEN);

  mode_t             mode, mode_next;
  logic [7:0]        word_bytes [MAX_KEYWORD_LEN];
  logic [LEN_W-1:0]  word_length, word_length_next;
  logic              dot_seen, dot_seen_next;
  logic [7:0]        previous_byte, previous_byte_next;
  logic [LINE_W-1:0] line_count, line_count_next;
  logic [LINE_W-1:0] column_count, column_count_next;
  logic [LINE_W-1:0] tok_line, tok_line_next;
  logic [LINE_W-1:0] tok_col, tok_col_next;
  logic [OFF_W-1:0]  byte_offset, byte_offset_next;
  logic [OFF_W-1:0]  tok_off, tok_off_next;

  logic [KW_BYTES*8-1:0] word_flat;
  logic [KIND_W-1:0]     word_kind;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  tok_t                  recs [2];
  logic [1:0]            n;
  logic                  do_idle;

  // Flatten the leading bytes for the keyword compare
  always_comb begin
    for (int i = 0; i < KW_BYTES; i++) word_flat[8*i +: 8] = word_bytes[i];
  end

  assign word_kind = (mode == M_IDENT) ? kw_kind(word_flat, word_length) : K_NUMBER;

  // Next scanner mode
  always_comb begin
    mode_next = mode;
    if (accept) begin
      if (opcode == OP_END) begin
        mode_next = M_IDLE;
      end else begin
        case (mode)
          M_IDENT:  mode_next = (is_alpha(text_byte) || is_digit(text_byte)) ?
                                M_IDENT : idle_mode(text_byte);
          M_NUMBER: mode_next = (is_digit(text_byte) ||
                                (text_byte == CH_DOT && !dot_seen)) ?
                                M_NUMBER : idle_mode(text_byte);
          M_STRING: mode_next = (is_quote(text_byte) && previous_byte != CH_BSLASH) ?
                                M_IDLE : M_STRING;
          M_SLASH:  mode_next = (text_byte == CH_STAR) ? M_BSKIP :
                                (text_byte == CH_SLASH) ? M_LINE : idle_mode(text_byte);
          M_BSKIP:  mode_next = M_BBODY;
          M_BBODY:  mode_next = (text_byte == CH_SLASH && previous_byte == CH_STAR) ?
                                M_IDLE : M_BBODY;
          M_LINE:   mode_next = (text_byte == CH_NL) ? M_IDLE : M_LINE;
          default:  mode_next = idle_mode(text_byte);
        endcase
      end
    end
  end

  // Tokens and datapath updates
  always_comb begin
    word_length_next   = word_length;
    dot_seen_next      = dot_seen;
    previous_byte_next = previous_byte;
    line_count_next    = line_count;
    column_count_next  = column_count;
    tok_line_next      = tok_line;
    tok_col_next       = tok_col;
    byte_offset_next   = byte_offset;
    tok_off_next       = tok_off;
    recs[0]            = '0;
    recs[1]            = '0;
    n                  = 2'd0;
    do_idle            = 1'b0;
    wr_en              = 1'b0;
    wr_idx             = '0;

    if (opcode == OP_END) begin
      // Close any open token, then add the end token
      case (mode)
        M_IDENT, M_NUMBER: begin
          recs[n[0]] = mk_tok(word_kind, 8'd0, tok_line, tok_col, tok_off, word_length);
          n = n + 2'd1;
          column_count_next = add20(column_count_next, word_length);
        end
        M_STRING: begin
          recs[n[0]] = mk_tok(K_STRING, 8'd0, line_count, column_count, tok_off,
                              word_length);
          n = n + 2'd1;
        end
        M_SLASH: begin
          recs[n[0]] = mk_tok(K_PUNCT, CH_SLASH, tok_line, tok_col, tok_off, 16'd1);
          n = n + 2'd1;
        end
        M_BSKIP, M_BBODY: begin
          recs[n[0]] = mk_tok(K_COMMENT, 8'd0, line_count, column_count, tok_off,
                              word_length);
          n = n + 2'd1;
        end
        M_LINE: begin
          recs[n[0]] = mk_tok(K_COMMENT, 8'd0, tok_line, tok_col, tok_off, word_length);
          n = n + 2'd1;
        end
        default: ;
      endcase
      recs[n[0]] = mk_tok(K_END, 8'd0, line_count_next, column_count_next,
                          byte_offset, 16'd0);
      n = n + 2'd1;
      word_length_next   = '0;
      dot_seen_next      = 1'b0;
      previous_byte_next = '0;
      line_count_next    = 20'd1;
      column_count_next  = 20'd1;
      tok_line_next      = '0;
      tok_col_next       = '0;
      byte_offset_next   = '0;
      tok_off_next       = '0;
    end else begin
      case (mode)
        M_IDENT, M_NUMBER: begin
          if (mode == M_IDENT && (is_alpha(text_byte) || is_digit(text_byte))) begin
            wr_en  = (word_length < LEN_W'(MAX_KEYWORD_LEN));
            wr_idx = word_length[IDX_W-1:0];
            word_length_next = inc16(word_length);
          end else if (mode == M_NUMBER && is_digit(text_byte)) begin
            word_length_next = inc16(word_length);
          end else if (mode == M_NUMBER && text_byte == CH_DOT && !dot_seen) begin
            dot_seen_next    = 1'b1;
            word_length_next = inc16(word_length);
          end else begin
            recs[n[0]] = mk_tok(word_kind, 8'd0, tok_line, tok_col, tok_off, word_length);
            n = n + 2'd1;
            column_count_next = add20(column_count, word_length);
            do_idle = 1'b1;
          end
        end
        M_STRING: begin
          if (is_quote(text_byte) && previous_byte != CH_BSLASH) begin
            recs[n[0]] = mk_tok(K_STRING, 8'd0, line_count, column_count, tok_off,
                                word_length);
            n = n + 2'd1;
          end else begin
            if (text_byte == CH_NL) begin
              line_count_next   = inc20(line_count);
              column_count_next = 20'd1;
            end else begin
              column_count_next = inc20(column_count);
            end
            word_length_next = inc16(word_length);
          end
        end
        M_SLASH: begin
          if (text_byte == CH_STAR) begin
            column_count_next = add20(column_count, 16'd3);
            word_length_next  = 16'd2;
          end else if (text_byte == CH_SLASH) begin
            word_length_next = 16'd2;
          end else begin
            recs[n[0]] = mk_tok(K_PUNCT, CH_SLASH, tok_line, tok_col, tok_off, 16'd1);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_BSKIP: begin
          word_length_next = inc16(word_length);
        end
        M_BBODY: begin
          if (text_byte == CH_SLASH && previous_byte == CH_STAR) begin
            recs[n[0]] = mk_tok(K_COMMENT, 8'd0, line_count, column_count, tok_off,
                                word_length);
            n = n + 2'd1;
          end else begin
            if (text_byte == CH_NL) begin
              line_count_next   = inc20(line_count);
              column_count_next = 20'd1;
            end else begin
              column_count_next = inc20(column_count);
            end
            word_length_next = inc16(word_length);
          end
        end
        M_LINE: begin
          if (text_byte == CH_NL) begin
            recs[n[0]] = mk_tok(K_COMMENT, 8'd0, tok_line, tok_col, tok_off, word_length);
            n = n + 2'd1;
            line_count_next   = inc20(line_count);
            column_count_next = 20'd1;
          end else begin
            word_length_next = inc16(word_length);
          end
        end
        default: do_idle = 1'b1;
      endcase

      // Scan the byte as if from idle
      if (do_idle) begin
        if (text_byte == CH_NL) begin
          line_count_next   = inc20(line_count_next);
          column_count_next = 20'd1;
        end else if (text_byte <= CH_SPACE || text_byte[7]) begin
          column_count_next = inc20(column_count_next);
        end else if (is_alpha(text_byte)) begin
          tok_line_next    = line_count_next;
          tok_col_next     = column_count_next;
          tok_off_next     = byte_offset;
          wr_en            = 1'b1;
          wr_idx           = '0;
          word_length_next = 16'd1;
        end else if (is_digit(text_byte)) begin
          tok_line_next    = line_count_next;
          tok_col_next     = column_count_next;
          tok_off_next     = byte_offset;
          word_length_next = 16'd1;
          dot_seen_next    = 1'b0;
        end else if (is_quote(text_byte)) begin
          column_count_next = inc20(column_count_next);
          tok_line_next     = line_count_next;
          tok_col_next      = column_count_next;
          tok_off_next      = inc32(byte_offset);
          word_length_next  = '0;
        end else if (text_byte == CH_SLASH) begin
          tok_line_next = line_count_next;
          tok_col_next  = column_count_next;
          tok_off_next  = byte_offset;
        end else begin
          recs[n[0]] = mk_tok(K_PUNCT, text_byte, line_count_next, column_count_next,
                              byte_offset, 16'd1);
          n = n + 2'd1;
        end
      end

      previous_byte_next = text_byte;
      byte_offset_next   = inc32(byte_offset);
    end

    // Mark the final token of this transfer
    if (n == 2'd1) recs[0].last = 1'b1;
    if (n == 2'd2) recs[1].last = 1'b1;
  end

  assign push_n = accept ? n : 2'd0;
  assign tok0   = recs[0];
  assign tok1   = recs[1];

  // Word byte store, no reset
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_BYTE && wr_en) word_bytes[wr_idx] <= text_byte;
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      word_length   <= '0;
      dot_seen      <= 1'b0;
      previous_byte <= '0;
      line_count    <= 20'd1;
      column_count  <= 20'd1;
      tok_line      <= '0;
      tok_col       <= '0;
      byte_offset   <= '0;
      tok_off       <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      word_length   <= word_length_next;
      dot_seen      <= dot_seen_next;
      previous_byte <= previous_byte_next;
      line_count    <= line_count_next;
      column_count  <= column_count_next;
      tok_line      <= tok_line_next;
      tok_col       <= tok_col_next;
      byte_offset   <= byte_offset_next;
      tok_off       <= tok_off_next;
    end
  end

endmodule

@@ rtl/core/stl_queue.sv @@
// Token queue between scanner front and output stage: two pushes, one pop.
// Depends on stl_pkg.
module stl_queue import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  tok_t       tok0,
  input  tok_t       tok1,
  input  logic       pop,
  output tok_t       head,
  output logic       not_empty,
  output logic       full
);

  localparam int DEPTH = 4;

  tok_t       mem [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != 3'd0);
  // Room for two tokens is needed before the front takes a byte
  assign full      = (count > 3'd2);

  assign count_next = count + {1'b0, push_n} - {2'b00, pop};

  // Write up to two entries
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr] <= tok0;
    if (push_n == 2'd2) mem[wr_ptr + 2'd1] <= tok1;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(DEPTH))
    else $error("token queue overflow");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> push_n == 2'd0)
    else $error("push into full token queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty token queue");

endmodule

@@ rtl/core/stl_back.sv @@
// Output stage: pops tokens from the queue into the output register.
// Depends on stl_pkg; takes the head entry from stl_queue.
module stl_back import stl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  tok_t head,
  input  logic not_empty,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output tok_t tok
);

  // Load a new token when the register is empty or being drained
  assign pop = not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) tok <= head;
  end

endmodule
